// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, spq_ctrl and sorted_priority_queue; depends on nothing.
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int PRI_BITS    = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_QUERY  = 2'd3
  } spq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } spq_status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_SHIFT,
    OP_DROP_ID
  } spq_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REINSERT,
    S_REPORT
  } spq_state_t;

  typedef struct packed {
    logic                vld;
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
  } spq_slot_t;

  typedef struct packed {
    spq_op_t             op;
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
  } spq_cmd_t;

endpackage

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::spq_cmd_t cmd,
  input  spq_pkg::spq_slot_t left_slot,
  input  logic              left_keep,
  input  spq_pkg::spq_slot_t right_slot,
  input  logic              hit_in,
  output spq_pkg::spq_slot_t slot,
  output logic              keep,
  output logic              hit_out
);

  logic                         vld_r, vld_nxt;
  logic [spq_pkg::ID_BITS-1:0]  id_r, id_nxt;
  logic [spq_pkg::PRI_BITS-1:0] pri_r, pri_nxt;

  assign slot = '{vld: vld_r, id: id_r, pri: pri_r};

  // Entry stays put on insert when it strictly outranks the new one.
  assign keep    = vld_r && ($signed(pri_r) > $signed(cmd.pri));
  assign hit_out = hit_in || (vld_r && (id_r == cmd.id));

  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    pri_nxt = pri_r;
    case (cmd.op)
      spq_pkg::OP_PUSH: begin
        if (!keep) begin
          if (left_keep) begin
            vld_nxt = 1'b1;
            id_nxt  = cmd.id;
            pri_nxt = cmd.pri;
          end else begin
            vld_nxt = left_slot.vld;
            id_nxt  = left_slot.id;
            pri_nxt = left_slot.pri;
          end
        end
      end
      spq_pkg::OP_SHIFT: begin
        vld_nxt = right_slot.vld;
        id_nxt  = right_slot.id;
        pri_nxt = right_slot.pri;
      end
      spq_pkg::OP_DROP_ID: begin
        // At and past the first matching slot, close the gap.
        if (hit_out) begin
          vld_nxt = right_slot.vld;
          id_nxt  = right_slot.id;
          pri_nxt = right_slot.pri;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    pri_r <= pri_nxt;
  end

endmodule

// File: hw/rtl/spq_ctrl.sv
// Sequencer for the sorted priority queue: handshakes, count, command and result register.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [spq_pkg::ID_BITS-1:0]  in_entry_id,
  input  logic [spq_pkg::PRI_BITS-1:0] in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_head_valid,
  output logic [spq_pkg::ID_BITS-1:0]  out_head_id,
  output logic [spq_pkg::ID_BITS-1:0]  out_removed_id,
  output logic                         out_is_head,
  output logic [spq_pkg::CNT_W-1:0]    out_entry_count,
  output spq_pkg::spq_cmd_t            cmd,
  input  spq_pkg::spq_slot_t           head_slot,
  input  logic                         found
);

  spq_pkg::spq_state_t          state_r, state_nxt;
  logic [spq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [spq_pkg::ID_BITS-1:0]  id_r;
  logic [spq_pkg::PRI_BITS-1:0] pri_r;
  spq_pkg::spq_status_t         status_r, status_nxt;
  logic [spq_pkg::ID_BITS-1:0]  removed_r, removed_nxt;
  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic                         out_head_valid_r;
  logic [spq_pkg::ID_BITS-1:0]  out_head_id_r;
  logic [spq_pkg::ID_BITS-1:0]  out_removed_id_r;
  logic                         out_is_head_r;
  logic [spq_pkg::CNT_W-1:0]    out_entry_count_r;

  logic accept;
  logic load_out;
  logic is_full;
  logic is_empty;
  spq_pkg::spq_mode_t mode;

  assign mode     = spq_pkg::spq_mode_t'(in_mode);
  assign is_full  = (count_r == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (mode == spq_pkg::MODE_UPDATE && found) begin
            state_nxt = spq_pkg::S_REINSERT;
          end else begin
            state_nxt = spq_pkg::S_REPORT;
          end
        end
      end
      spq_pkg::S_REINSERT: state_nxt = spq_pkg::S_REPORT;
      spq_pkg::S_REPORT:   state_nxt = spq_pkg::S_IDLE;
      default:             state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    load_out    = 1'b0;
    cmd         = '{op: spq_pkg::OP_HOLD, id: in_entry_id, pri: in_priority_req};
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (accept) begin
          status_nxt  = spq_pkg::ST_DONE;
          removed_nxt = '0;
          unique case (mode)
            spq_pkg::MODE_INSERT: begin
              if (is_full) begin
                status_nxt = spq_pkg::ST_FULL;
              end else begin
                cmd.op    = spq_pkg::OP_PUSH;
                count_nxt = count_r + spq_pkg::CNT_W'(1);
              end
            end
            spq_pkg::MODE_POP: begin
              if (is_empty) begin
                status_nxt = spq_pkg::ST_EMPTY;
              end else begin
                cmd.op      = spq_pkg::OP_SHIFT;
                removed_nxt = head_slot.id;
                count_nxt   = count_r - spq_pkg::CNT_W'(1);
              end
            end
            spq_pkg::MODE_UPDATE: begin
              // No hit leaves every cell unchanged.
              cmd.op = spq_pkg::OP_DROP_ID;
              if (found) begin
                count_nxt = count_r - spq_pkg::CNT_W'(1);
              end else begin
                status_nxt = spq_pkg::ST_NOT_FOUND;
              end
            end
            spq_pkg::MODE_QUERY: begin
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::S_REINSERT: begin
        cmd       = '{op: spq_pkg::OP_PUSH, id: id_r, pri: pri_r};
        count_nxt = count_r + spq_pkg::CNT_W'(1);
      end
      spq_pkg::S_REPORT: begin
        load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (accept) begin
      id_r  <= in_entry_id;
      pri_r <= in_priority_req;
    end
    if (load_out) begin
      out_status_r      <= status_r;
      out_head_valid_r  <= !is_empty;
      out_head_id_r     <= is_empty ? '0 : head_slot.id;
      out_removed_id_r  <= removed_r;
      out_is_head_r     <= !is_empty && (head_slot.id == id_r);
      out_entry_count_r <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_head_valid  = out_head_valid_r;
  assign out_head_id     = out_head_id_r;
  assign out_removed_id  = out_removed_id_r;
  assign out_is_head     = out_is_head_r;
  assign out_entry_count = out_entry_count_r;

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of slot cells under one sequencer.
// Depends on spq_pkg, spq_cell and spq_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per operation:
//   in_mode selects insert, pop, update or query; in_entry_id and
//   in_priority_req are the operands. Output channel (out_valid / out_stall)
//   returns one transaction per operation with status, head, removed id,
//   head match and entry count as they stand after the operation.
//   Entries live in a row of QUEUE_DEPTH cells, kept sorted with the highest
//   priority in cell 0. Insert and pop each send one command down the row;
//   query leaves it alone; update pulls the id out and, if it was found,
//   pushes it back with the new priority. The result is registered in the
//   report state, entered straight from acceptance or, for a found update,
//   after the reinsert state; a new transaction is taken only in the idle state.
//   Reset: synchronous, clears the sequencer, the count, the output valid
//   flag and every cell's valid flag; the queue starts empty and ready at once.
//   A stalled result holds in the output register; no new transaction is
//   taken until that result is gone or is being taken in the same cycle.
module sorted_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [spq_pkg::ID_BITS-1:0]  in_entry_id,
  input  logic [spq_pkg::PRI_BITS-1:0] in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_head_valid,
  output logic [spq_pkg::ID_BITS-1:0]  out_head_id,
  output logic [spq_pkg::ID_BITS-1:0]  out_removed_id,
  output logic                         out_is_head,
  output logic [spq_pkg::CNT_W-1:0]    out_entry_count
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_slot_t slots [N];
  logic               keeps [N];
  logic               hits  [N];

  spq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_entry_id     (in_entry_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_head_valid  (out_head_valid),
    .out_head_id     (out_head_id),
    .out_removed_id  (out_removed_id),
    .out_is_head     (out_is_head),
    .out_entry_count (out_entry_count),
    .cmd             (cmd),
    .head_slot       (slots[0]),
    .found           (hits[N-1])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::spq_slot_t left_slot;
    spq_pkg::spq_slot_t right_slot;
    logic               left_keep;
    logic               hit_in;

    if (i == 0) begin : g_first
      assign left_slot = '0;
      assign left_keep = 1'b1;
      assign hit_in    = 1'b0;
    end else begin : g_mid
      assign left_slot = slots[i-1];
      assign left_keep = keeps[i-1];
      assign hit_in    = hits[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .left_keep  (left_keep),
      .right_slot (right_slot),
      .hit_in     (hit_in),
      .slot       (slots[i]),
      .keep       (keeps[i]),
      .hit_out    (hits[i])
    );
  end

endmodule
